/* rtl/core/dbd_pkg.sv */
// Shared constants and the month-start table for the days-between-dates unit.
// No dependencies; used by dbd_lane, dbd_merge and days_between_dates_unit.
package dbd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DAYS_W  = 22;
  localparam int PIPE_DEPTH = 5;

  localparam logic [YEAR_W-1:0] BASE_YEAR = 14'd1971;
  localparam logic [YEAR_W-1:0] TOP_YEAR  = 14'd9999;

  // leaps_upto(1970) = 492 - 19 + 4
  localparam logic [11:0] BASE_LEAPS = 12'd477;

  // floor(n / 100) = (n * 5243) >> 19, exact for n below 16384
  localparam logic [12:0] RECIP100 = 13'd5243;
  localparam int          RECIP_SH = 19;

  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

  // days before month m in a common year; months 13 and 14 count 31 days each
  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:  r = 9'd31;
      4'd3:  r = 9'd59;
      4'd4:  r = 9'd90;
      4'd5:  r = 9'd120;
      4'd6:  r = 9'd151;
      4'd7:  r = 9'd181;
      4'd8:  r = 9'd212;
      4'd9:  r = 9'd243;
      4'd10: r = 9'd273;
      4'd11: r = 9'd304;
      4'd12: r = 9'd334;
      4'd13: r = 9'd365;
      4'd14: r = 9'd396;
      default: r = 9'd427;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/dbd_lane.sv */
// One lane: converts a date into its day number (1 Jan 1971 is day 1).
// Four register stages; uses dbd_pkg.
module dbd_lane (
  input  logic                          clk,
  input  logic [dbd_pkg::DAY_W-1:0]     day,
  input  logic [dbd_pkg::MONTH_W-1:0]   month,
  input  logic [dbd_pkg::YEAR_W-1:0]    year,
  output logic [dbd_pkg::DAYS_W-1:0]    day_num
);
  import dbd_pkg::*;

  // stage 1: clamped year
  logic [YEAR_W-1:0]  yr1;
  logic [MONTH_W-1:0] mo1;
  logic [DAY_W-1:0]   dy1;
  logic [YEAR_W-1:0]  yr_clamp;

  // stage 2: quotients by 100 and 400
  logic [YEAR_W-1:0]  yr2;
  logic [MONTH_W-1:0] mo2;
  logic [DAY_W-1:0]   dy2;
  logic [6:0]         q100_y2;
  logic [6:0]         q100_m2;
  logic [4:0]         q400_m2;
  logic [26:0]        prod_y;
  logic [26:0]        prod_m;
  logic [24:0]        prod_m4;
  logic [YEAR_W-1:0]  ym1;

  // stage 3: year part, leap count, days within year
  logic [DAYS_W-1:0]  years3;
  logic [11:0]        leaps3;
  logic [9:0]         dpart3;
  logic               is_leap;
  logic [YEAR_W-1:0]  cent;

  always_comb begin
    yr_clamp = year;
    if (year < BASE_YEAR) yr_clamp = BASE_YEAR;
    if (year > TOP_YEAR)  yr_clamp = TOP_YEAR;
  end

  always_ff @(posedge clk) begin
    yr1 <= yr_clamp;
    mo1 <= month;
    dy1 <= day;
  end

  assign ym1     = yr1 - 14'd1;
  assign prod_y  = 27'(yr1) * 27'(RECIP100);
  assign prod_m  = 27'(ym1) * 27'(RECIP100);
  assign prod_m4 = 25'(ym1[YEAR_W-1:2]) * 25'(RECIP100);

  always_ff @(posedge clk) begin
    yr2     <= yr1;
    mo2     <= mo1;
    dy2     <= dy1;
    q100_y2 <= 7'(prod_y >> RECIP_SH);
    q100_m2 <= 7'(prod_m >> RECIP_SH);
    q400_m2 <= 5'(prod_m4 >> RECIP_SH);
  end

  // year divisible by 100 exactly when the quotient times 100 gives it back;
  // by 400 when additionally the quotient is a multiple of 4
  assign cent    = 14'(q100_y2) * 14'd100;
  assign is_leap = (yr2[1:0] == 2'b00) &&
                   ((yr2 != cent) || (q100_y2[1:0] == 2'b00));

  always_ff @(posedge clk) begin
    years3 <= 22'(yr2 - BASE_YEAR) * 22'(DAYS_PER_YEAR);
    leaps3 <= 12'((yr2 - 14'd1) >> 2) - 12'(q100_m2) + 12'(q400_m2) - BASE_LEAPS;
    dpart3 <= 10'(month_start(mo2)) + 10'(is_leap && (mo2 > 4'd2)) + 10'(dy2);
  end

  always_ff @(posedge clk) begin
    day_num <= years3 + 22'(leaps3) + 22'(dpart3);
  end

endmodule

/* rtl/core/dbd_merge.sv */
// Merging stage: absolute difference of the two lanes' day numbers.
// One register stage; uses dbd_pkg.
module dbd_merge (
  input  logic                       clk,
  input  logic [dbd_pkg::DAYS_W-1:0] num_a,
  input  logic [dbd_pkg::DAYS_W-1:0] num_b,
  output logic [dbd_pkg::DAYS_W-1:0] diff
);
  import dbd_pkg::*;

  always_ff @(posedge clk) begin
    if (num_b >= num_a) begin
      diff <= num_b - num_a;
    end else begin
      diff <= num_a - num_b;
    end
  end

endmodule

/* rtl/core/days_between_dates_unit.sv */
// Top level of the days-between-dates unit: two date lanes and the merging stage.
// Depends on dbd_pkg, dbd_lane and dbd_merge.
//
//   channel   ports                                   beat marked by
//   -------   -------------------------------------   --------------
//   command   first_*/second_* day, month, year        start & !busy
//   result    days_apart                               done
//
// A beat is taken every cycle; busy never rises. Each result appears on
// days_apart with done high once its command beat has passed the four
// lane stages (clamp, quotients, partial sums, day number) and the
// difference register. Results keep command order and cannot be
// stalled. Synchronous reset clears only the done pipeline.
module days_between_dates_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dbd_pkg::DAY_W-1:0]   first_day,
  input  logic [dbd_pkg::MONTH_W-1:0] first_month,
  input  logic [dbd_pkg::YEAR_W-1:0]  first_year,
  input  logic [dbd_pkg::DAY_W-1:0]   second_day,
  input  logic [dbd_pkg::MONTH_W-1:0] second_month,
  input  logic [dbd_pkg::YEAR_W-1:0]  second_year,
  output logic                        done,
  output logic [dbd_pkg::DAYS_W-1:0]  days_apart
);
  import dbd_pkg::*;

  logic [DAYS_W-1:0]     num_a;
  logic [DAYS_W-1:0]     num_b;
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] vld_next;

  assign busy = 1'b0;

  dbd_lane u_lane_a (
    .clk     (clk),
    .day     (first_day),
    .month   (first_month),
    .year    (first_year),
    .day_num (num_a)
  );

  dbd_lane u_lane_b (
    .clk     (clk),
    .day     (second_day),
    .month   (second_month),
    .year    (second_year),
    .day_num (num_b)
  );

  dbd_merge u_merge (
    .clk   (clk),
    .num_a (num_a),
    .num_b (num_b),
    .diff  (days_apart)
  );

  assign vld_next = {vld[PIPE_DEPTH-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign done = vld[PIPE_DEPTH-1];

endmodule

/* dv/days_between_dates_unit_test.sv */
`timescale 1ns / 1ps
// Testbench for days_between_dates_unit: directed date pairs, then random pairs in
// three idle phases, each result checked against a typed expectation or a day-count predictor.
// Depends on dbd_pkg and the days_between_dates_unit RTL.
module days_between_dates_unit_test;

  import dbd_pkg::DAY_W;
  import dbd_pkg::MONTH_W;
  import dbd_pkg::YEAR_W;
  import dbd_pkg::DAYS_W;
  import dbd_pkg::PIPE_DEPTH;

  localparam int unsigned EPOCH_YEAR = 1971;
  localparam int unsigned LAST_YEAR  = 9999;
  localparam int          STALL_LIMIT = 500;
  localparam int          PHASE_BEATS = 150;

  typedef struct {
    logic [DAY_W-1:0]   d1;
    logic [MONTH_W-1:0] m1;
    logic [YEAR_W-1:0]  y1;
    logic [DAY_W-1:0]   d2;
    logic [MONTH_W-1:0] m2;
    logic [YEAR_W-1:0]  y2;
    bit                 typed;
    logic [DAYS_W-1:0]  want;
  } date_pair_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [DAY_W-1:0]   first_day = '0;
  logic [MONTH_W-1:0] first_month = '0;
  logic [YEAR_W-1:0]  first_year = '0;
  logic [DAY_W-1:0]   second_day = '0;
  logic [MONTH_W-1:0] second_month = '0;
  logic [YEAR_W-1:0]  second_year = '0;
  logic               done;
  logic [DAYS_W-1:0]  days_apart;

  logic [DAYS_W-1:0] days_due[$];
  date_pair_t        directed[$];
  int                mismatches = 0;
  int                stall_cycles = 0;

  days_between_dates_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .first_day    (first_day),
    .first_month  (first_month),
    .first_year   (first_year),
    .second_day   (second_day),
    .second_month (second_month),
    .second_year  (second_year),
    .done         (done),
    .days_apart   (days_apart)
  );

  always #10 clk = ~clk;

  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned leaps_through(int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  // cumulative days before month m; 13 and 14 each count as 31-day months
  function automatic int unsigned days_before_month(logic [MONTH_W-1:0] m);
    int unsigned r;
    case (m)
      4'd0, 4'd1: r = 0;
      4'd2:  r = 31;
      4'd3:  r = 59;
      4'd4:  r = 90;
      4'd5:  r = 120;
      4'd6:  r = 151;
      4'd7:  r = 181;
      4'd8:  r = 212;
      4'd9:  r = 243;
      4'd10: r = 273;
      4'd11: r = 304;
      4'd12: r = 334;
      4'd13: r = 365;
      4'd14: r = 396;
      default: r = 427;
    endcase
    return r;
  endfunction

  function automatic int unsigned day_index(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                            logic [YEAR_W-1:0] y);
    int unsigned yr;
    int unsigned n;
    yr = y;
    if (yr < EPOCH_YEAR) yr = EPOCH_YEAR;
    if (yr > LAST_YEAR) yr = LAST_YEAR;
    n = (yr - EPOCH_YEAR) * 365 + leaps_through(yr - 1) - leaps_through(EPOCH_YEAR - 1);
    n += days_before_month(m);
    if (m > 2 && is_leap(yr)) n += 1;
    return n + d;
  endfunction

  function automatic logic [DAYS_W-1:0] days_between(date_pair_t p);
    int unsigned a;
    int unsigned b;
    a = day_index(p.d1, p.m1, p.y1);
    b = day_index(p.d2, p.m2, p.y2);
    return (b >= a) ? DAYS_W'(b - a) : DAYS_W'(a - b);
  endfunction

  function automatic date_pair_t row(int d1, int m1, int y1, int d2, int m2, int y2,
                                     bit typed = 1'b0, int want = 0);
    date_pair_t p;
    p.d1 = DAY_W'(d1);  p.m1 = MONTH_W'(m1);  p.y1 = YEAR_W'(y1);
    p.d2 = DAY_W'(d2);  p.m2 = MONTH_W'(m2);  p.y2 = YEAR_W'(y2);
    p.typed = typed;
    p.want = DAYS_W'(want);
    return p;
  endfunction

  function automatic logic [DAY_W-1:0] rand_day();
    return ($urandom_range(0, 9) == 0) ? DAY_W'($urandom_range(0, 31))
                                       : DAY_W'($urandom_range(1, 31));
  endfunction

  function automatic logic [MONTH_W-1:0] rand_month();
    return ($urandom_range(0, 9) == 0) ? MONTH_W'($urandom_range(0, 15))
                                       : MONTH_W'($urandom_range(1, 12));
  endfunction

  function automatic logic [YEAR_W-1:0] rand_year();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return YEAR_W'($urandom_range(0, 16383));
    if (sel == 1) return YEAR_W'($urandom_range(1971, 2104));
    return YEAR_W'($urandom_range(1971, 9999));
  endfunction

  function automatic date_pair_t rand_pair();
    date_pair_t p;
    p.d1 = rand_day();  p.m1 = rand_month();  p.y1 = rand_year();
    if ($urandom_range(0, 19) == 0) begin
      p.d2 = p.d1;  p.m2 = p.m1;  p.y2 = p.y1;
    end else begin
      p.d2 = rand_day();  p.m2 = rand_month();  p.y2 = rand_year();
    end
    p.typed = 1'b0;
    p.want = '0;
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [DAYS_W-1:0] want,
                                 logic [DAYS_W-1:0] got);
    $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    mismatches++;
  endtask

  // one command beat; the expectation is queued at the edge that takes it
  task automatic send_dates(date_pair_t p, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    first_day    <= p.d1;
    first_month  <= p.m1;
    first_year   <= p.y1;
    second_day   <= p.d2;
    second_month <= p.m2;
    second_year  <= p.y2;
    @(posedge clk);
    while (busy) @(posedge clk);
    days_due.push_back(p.typed ? p.want : days_between(p));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (days_due.size() != 0) @(posedge clk);
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (days_due.size() == 0) begin
          report_mismatch("result with nothing pending", '0, days_apart);
        end else if (days_apart !== days_due[0]) begin
          report_mismatch("days_apart", days_due[0], days_apart);
          void'(days_due.pop_front());
        end else begin
          void'(days_due.pop_front());
        end
      end
      if ((start && !busy) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("days_between_dates_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    int idle_pct[3];
    idle_pct = '{22, 72, 0};

    directed.push_back(row(1, 1, 1971, 1, 1, 1971, 1, 0));
    directed.push_back(row(1, 1, 1971, 2, 1, 1971, 1, 1));
    directed.push_back(row(1, 1, 1971, 1, 1, 1972, 1, 365));
    directed.push_back(row(1, 1, 1972, 1, 1, 1973, 1, 366));
    directed.push_back(row(31, 12, 9999, 1, 1, 1971));
    // years outside 1971..9999 clamp to the ends
    directed.push_back(row(1, 1, 0, 1, 1, 1971, 1, 0));
    directed.push_back(row(1, 1, 1970, 1, 1, 1971, 1, 0));
    directed.push_back(row(5, 6, 16383, 5, 6, 9999, 1, 0));
    // day zero and day past month end are added as given
    directed.push_back(row(0, 3, 2000, 1, 3, 2000, 1, 1));
    directed.push_back(row(31, 1, 1990, 0, 2, 1990, 1, 0));
    directed.push_back(row(1, 0, 1980, 1, 1, 1980, 1, 0));
    // months 13 and 14 run on as 31-day months
    directed.push_back(row(1, 13, 2001, 1, 1, 2002, 1, 0));
    directed.push_back(row(1, 13, 2004, 1, 1, 2005, 1, 0));
    directed.push_back(row(1, 14, 1971, 1, 15, 1971, 1, 31));
    directed.push_back(row(1, 15, 9999, 31, 0, 1971));
    directed.push_back(row(29, 2, 2000, 1, 3, 2000, 1, 1));
    directed.push_back(row(28, 2, 2100, 1, 3, 2100, 1, 1));
    directed.push_back(row(29, 2, 2100, 1, 3, 2100, 1, 0));
    directed.push_back(row(1, 3, 2400, 1, 3, 2399));
    directed.push_back(row(31, 15, 16383, 0, 0, 0));
    directed.push_back(row(15, 7, 2023, 4, 2, 1999));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_dates(directed[i], 0);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < PHASE_BEATS; n++) send_dates(rand_pair(), idle_pct[ph]);
      drain_results();
    end

    repeat (3 * PIPE_DEPTH) @(posedge clk);
    if (days_due.size() != 0) report_mismatch("results never arrived", '0, '0);
    if (mismatches == 0) begin
      $display("days_between_dates_unit verification clean");
    end else begin
      $display("days_between_dates_unit verification failed");
    end
    $finish;
  end

endmodule
